FILE: hw/rtl/ssr_pkg.sv
// ssr_pkg: shared types and constants for the stream substring replace core
// used by the front end, the command queue, the back end and the top level
// no dependencies
package ssr_pkg;

  // most bytes one input beat can produce (replacement or window flush)
  localparam int MAX_OUT = 8;
  // command queue depth
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_PAT_LEN   = 2'd0,
    CFG_PAT_BYTES = 2'd1,
    CFG_REP_LEN   = 2'd2,
    CFG_REP_BYTES = 2'd3
  } cfg_idx_e;

  // configuration write bundle
  typedef struct packed {
    logic        we;
    logic [1:0]  index;
    logic [63:0] data;
  } cfg_wr_t;

  // one output command: up to MAX_OUT bytes, a count, and the end flag
  // a zero count with last set stands for the empty end marker
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [3:0]              count;
    logic                    last;
  } cmd_t;

endpackage

FILE: hw/rtl/ssr_front.sv
// ssr_front: configuration registers, match window and beat classification
// turns each accepted input beat into at most one output command
// depends on ssr_pkg
module ssr_front import ssr_pkg::*; #(
  parameter int MAX_PATTERN = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_wr_t    cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data,
  input  logic       in_last,
  output logic       push,
  output cmd_t       push_cmd,
  input  logic       q_ready
);

  localparam int FW = $clog2(MAX_PATTERN + 1);

  // configuration registers
  logic [3:0]  pat_len;
  logic [63:0] pat_bytes;
  logic [3:0]  rep_len;
  logic [63:0] rep_bytes;

  // window
  logic [MAX_PATTERN-1:0][7:0] win;
  logic [MAX_PATTERN-1:0][7:0] win_new;
  logic [MAX_PATTERN-1:0][7:0] win_next;
  logic [FW-1:0]               fill;
  logic [FW-1:0]               fill_next;

  logic [3:0] fill4;
  logic [3:0] p_eff;
  logic [3:0] r_eff;
  logic       full;
  logic       match;
  logic       accept;
  logic [3:0] count;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign fill4    = 4'(fill);
  assign p_eff    = (pat_len > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN) : pat_len;
  assign r_eff    = (rep_len > 4'(MAX_OUT)) ? 4'(MAX_OUT) : rep_len;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len   <= '0;
      pat_bytes <= '0;
      rep_len   <= '0;
      rep_bytes <= '0;
    end else if (cfg.we) begin
      unique case (cfg_idx_e'(cfg.index))
        CFG_PAT_LEN:   pat_len   <= cfg.data[3:0];
        CFG_PAT_BYTES: pat_bytes <= cfg.data;
        CFG_REP_LEN:   rep_len   <= cfg.data[3:0];
        CFG_REP_BYTES: rep_bytes <= cfg.data;
        default:       ;
      endcase
    end
  end

  // window with the new byte placed at the fill position
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_new[i] = (fill4 == 4'(i)) ? in_data : win[i];
    end
  end

  // compare the first p_eff bytes against the pattern
  assign full = (p_eff != 4'd0) && (fill4 == p_eff - 4'd1);

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((4'(i) < p_eff) && (win_new[i] != pat_bytes[8*i +: 8])) begin
        match = 1'b0;
      end
    end
  end

  // build the command
  always_comb begin
    for (int i = 0; i < MAX_OUT; i++) begin
      if (full && match) begin
        push_cmd.bytes[i] = rep_bytes[8*i +: 8];
      end else if (i < MAX_PATTERN) begin
        push_cmd.bytes[i] = win_new[i];
      end else begin
        push_cmd.bytes[i] = 8'd0;
      end
    end
    if (p_eff == 4'd0) begin
      count = 4'd1;
    end else if (full && match) begin
      count = r_eff;
    end else if (full) begin
      count = in_last ? p_eff : 4'd1;
    end else begin
      count = in_last ? fill4 + 4'd1 : 4'd0;
    end
    push_cmd.count = count;
    push_cmd.last  = in_last;
    push           = accept && ((count != 4'd0) || in_last);
  end

  // next window and fill
  always_comb begin
    win_next  = win_new;
    fill_next = fill;
    if (p_eff == 4'd0) begin
      fill_next = fill;
    end else if (full && match) begin
      fill_next = '0;
    end else if (full) begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        win_next[i] = win_new[i+1];
      end
      fill_next = in_last ? '0 : FW'(p_eff - 4'd1);
    end else begin
      fill_next = in_last ? '0 : FW'(fill4 + 4'd1);
    end
  end

  // fill count, cleared by a pattern length write
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cfg.we && (cfg_idx_e'(cfg.index) == CFG_PAT_LEN)) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  // window bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      win <= win_next;
    end
  end

  // held bytes never reach a full window
  a_fill_below_len: assert property (@(posedge clk) disable iff (rst)
    (p_eff != 4'd0) |-> (fill4 < p_eff))
    else $error("window fill reached pattern length");

endmodule

FILE: hw/rtl/ssr_cmd_fifo.sv
// ssr_cmd_fifo: short queue of output commands between front and back end
// depends on ssr_pkg
module ssr_cmd_fifo import ssr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic ready,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic valid
);

  cmd_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] cnt;

  assign ready   = (cnt != Q_CNT_W'(Q_DEPTH));
  assign valid   = (cnt != '0);
  assign pop_cmd = entries[rd_ptr];

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> ready)
    else $error("command pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid)
    else $error("command popped from empty queue");

  a_cnt_tracks: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (cnt == $past(cnt) + 1'b1))
    else $error("queue occupancy did not follow a push");

endmodule

FILE: hw/rtl/ssr_back.sv
// ssr_back: serialises queued commands into output beats, one byte a beat
// the held command doubles as the output register
// depends on ssr_pkg
module ssr_back import ssr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       out_last
);

  logic       active;
  cmd_t       cur;
  logic [2:0] idx;
  logic       finish;
  logic       take;

  assign out_valid = active;
  assign take      = active && out_ready;
  assign finish    = (cur.count == 4'd0) || (({1'b0, idx} + 4'd1) == cur.count);
  assign pop       = q_valid && (!active || (take && finish));

  // beat sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (pop) begin
      active <= 1'b1;
      idx    <= '0;
    end else if (take && finish) begin
      active <= 1'b0;
    end else if (take) begin
      idx <= idx + 3'd1;
    end
  end

  // held command
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_cmd;
    end
  end

  // beat fields
  assign has_byte = (cur.count != 4'd0);
  assign out_byte = has_byte ? cur.bytes[idx] : 8'd0;
  assign out_last = cur.last && finish;

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_byte) |-> out_last)
    else $error("empty marker beat without end flag");

endmodule

FILE: hw/rtl/stream_substring_replace_core.sv
// stream_substring_replace_core: top level of the streaming find and replace
// joins ssr_front, ssr_cmd_fifo and ssr_back; depends on ssr_pkg
//
// channel  direction  payload
// s_*      in         tdata = data_byte[7:0], tlast = end_of_string
// m_*      out        tdata = out_byte[7:0], tuser = has_byte, tlast = out_last
// cfg_*    in         cfg_index selects register, cfg_data[63:0] write data
//
// one input beat a cycle while the command queue has room; a beat that emits
// one byte sustains one beat a cycle end to end while m_tready stays high
// a beat that emits n bytes (n up to 8) holds the back end until all are sent,
// and the two-entry command queue sets how long the input flows meanwhile
// a command is registered in the queue, then as the back end's held command
// synchronous reset clears the queue, window fill, config and back end state
module stream_substring_replace_core import ssr_pkg::*; #(
  parameter int MAX_PATTERN = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte
  output logic        m_tuser,   // has_byte
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_wr_t cfg;
  logic    push;
  cmd_t    push_cmd;
  logic    q_ready;
  logic    pop;
  cmd_t    pop_cmd;
  logic    q_valid;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // front end: window and classification
  ssr_front #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  (s_tdata),
    .in_last  (s_tlast),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready)
  );

  // command queue
  ssr_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .ready    (q_ready),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .valid    (q_valid)
  );

  // back end: byte serialiser
  ssr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (pop_cmd),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .has_byte  (m_tuser),
    .out_last  (m_tlast)
  );

endmodule
